@@ rtl/pim_pkg.sv @@
// Package for the priority inheritance lock unit: widths, status codes and the bucket function.
// No dependencies.
`timescale 1ns / 1ps
package pim_pkg;
  localparam int MaxWaiters = 16;
  localparam int IdxW = $clog2(MaxWaiters);
  localparam int CntW = $clog2(MaxWaiters + 1);
  localparam int TaskW = 5;
  localparam int PrioW = 8;
  localparam int NumBuckets = 8;
  localparam int BucketShift = 5;
  localparam int EntryW = TaskW + 2 * PrioW;

  typedef enum logic [2:0] {
    ST_ACQUIRED    = 3'd0,
    ST_OWNER_AGAIN = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_NOT_OWNER   = 3'd3,
    ST_FULL        = 3'd4,
    ST_RELEASED    = 3'd5,
    ST_TO_REMOVED  = 3'd6,
    ST_TO_ABSENT   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    K_LOCK    = 2'd0,
    K_UNLOCK  = 2'd1,
    K_TIMEOUT = 2'd2,
    K_NONE    = 2'd3
  } kind_e;

  function automatic logic [2:0] bucket_of(input logic [PrioW-1:0] p);
    logic [PrioW-1:0] b;
    b = p >> BucketShift;
    if (b >= PrioW'(NumBuckets)) begin
      b = PrioW'(NumBuckets - 1);
    end
    return b[2:0];
  endfunction
endpackage

@@ rtl/pim_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module pim_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/priority_inheritance_mutex.sv @@
// Top level of the priority inheritance lock unit.
// Uses pim_pkg and the waiter table pim_ram.
//
// Usage: requests arrive on the s_axis channel, one transaction per request, and each
// produces exactly one result transaction on m_axis. The single configuration register
// inherit_enable is written through cfg_we_i / cfg_wdata_i; the user must do so only while
// the block is idle, as the block itself does not enforce it. The waiter table sits in one
// RAM with a registered read. A request that needs no table access goes straight to S_OUT
// for its result. A queued lock with inheritance appends the entry and then scans the table
// for the lowest priority value, one read and one compare per entry. An unlock scans for
// the best waiter, then shifts later entries down, one read and one write per entry. A
// timeout searches and shifts in the same way. Each entry visited needs a wait state
// (S_SCANW or S_SHW) for the registered read of the single read port.
// The result is held in an output register; s_axis_tready stays low until the result
// has been taken, so a stalled receiver holds back further requests.
// Reset clears the lock and the waiter count and sets inherit_enable to 1; the table
// contents need no clearing as only entries below the count are read.
`timescale 1ns / 1ps
module priority_inheritance_mutex
  import pim_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  // tdata: task_id[4:0], task_priority[12:5], task_base_priority[20:13], zeros
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[2:0], is_locked[3], holder_id[8:4], holder_priority[16:9],
  // waiter_total[21:17], rebucket_valid[22], rebucket_task[27:23], rebucket_old[30:28],
  // rebucket_new[33:31], wake_valid[34], wake_id[39:35]
  output logic [39:0] m_axis_tdata
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SCANW = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_SHW   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic inh_q;
  logic held_q, held_d;
  logic [TaskW-1:0] holder_q, holder_d;
  logic [PrioW-1:0] hprio_q, hprio_d, hbase_q, hbase_d;
  logic [2:0] hbuck_q, hbuck_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  kind_e kind_q, kind_d;
  logic [TaskW-1:0] tid_q, tid_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] best_q, best_d;
  logic found_q, found_d;
  logic [EntryW-1:0] bent_q, bent_d;
  logic [39:0] out_q, out_d;
  logic ovalid_q, ovalid_d;

  logic ram_we;
  logic [IdxW-1:0] ram_wa, ram_ra;
  logic [EntryW-1:0] ram_wd, ram_rd;

  pim_ram #(.Width(EntryW), .Depth(MaxWaiters)) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  logic [TaskW-1:0] rd_task;
  logic [PrioW-1:0] rd_prio;
  assign rd_task = ram_rd[TaskW-1:0];
  assign rd_prio = ram_rd[TaskW+PrioW-1:TaskW];

  logic [1:0] in_kind;
  logic [TaskW-1:0] in_tid;
  logic [PrioW-1:0] in_prio, in_base;
  assign in_kind = s_axis_tuser;
  assign in_tid  = s_axis_tdata[4:0];
  assign in_prio = s_axis_tdata[12:5];
  assign in_base = s_axis_tdata[20:13];

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  function automatic logic [39:0] pack(
    input status_e st, input logic hl, input logic [TaskW-1:0] hd,
    input logic [PrioW-1:0] hp, input logic [CntW-1:0] c,
    input logic rv, input logic [TaskW-1:0] rt, input logic [2:0] ro,
    input logic [2:0] rn, input logic wv, input logic [TaskW-1:0] wi);
    return {wi, wv, rn, ro, rt, rv, c, hl ? hp : PrioW'(0), hl ? hd : TaskW'(0), hl, st};
  endfunction

  always_comb begin
    state_d = state_q; held_d = held_q; holder_d = holder_q; hprio_d = hprio_q;
    hbase_d = hbase_q; hbuck_d = hbuck_q; cnt_d = cnt_q; kind_d = kind_q; tid_d = tid_q;
    ptr_d = ptr_q; best_d = best_q; found_d = found_q; bent_d = bent_q;
    out_d = out_q; ovalid_d = ovalid_q;
    ram_we = 1'b0; ram_wa = ptr_q[IdxW-1:0]; ram_wd = ram_rd; ram_ra = ptr_q[IdxW-1:0];
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          kind_d = kind_e'(in_kind);
          tid_d = in_tid;
          ptr_d = '0; found_d = 1'b0; best_d = '0;
          ram_ra = '0;
          unique case (kind_e'(in_kind))
            K_LOCK: begin
              if (held_q && holder_q == in_tid) begin
                out_d = pack(ST_OWNER_AGAIN, held_q, holder_q, hprio_q, cnt_q,
                             1'b0, '0, '0, '0, 1'b0, '0);
                state_d = S_OUT;
              end else if (!held_q) begin
                held_d = 1'b1; holder_d = in_tid; hprio_d = in_prio; hbase_d = in_base;
                hbuck_d = bucket_of(in_prio);
                out_d = pack(ST_ACQUIRED, 1'b1, in_tid, in_prio, cnt_q,
                             1'b0, '0, '0, '0, 1'b0, '0);
                state_d = S_OUT;
              end else if (cnt_q >= CntW'(MaxWaiters)) begin
                out_d = pack(ST_FULL, held_q, holder_q, hprio_q, cnt_q,
                             1'b0, '0, '0, '0, 1'b0, '0);
                state_d = S_OUT;
              end else begin
                ram_we = 1'b1; ram_wa = cnt_q[IdxW-1:0];
                ram_wd = {in_base, in_prio, in_tid};
                cnt_d = cnt_q + 1'b1;
                if (inh_q) begin
                  bent_d = {in_base, in_prio, in_tid};
                  state_d = S_SCANW;
                end else begin
                  out_d = pack(ST_QUEUED, held_q, holder_q, hprio_q, cnt_q + 1'b1,
                               1'b0, '0, '0, '0, 1'b0, '0);
                  state_d = S_OUT;
                end
              end
            end
            K_UNLOCK: begin
              if (!held_q || holder_q != in_tid) begin
                out_d = pack(ST_NOT_OWNER, held_q, holder_q, hprio_q, cnt_q,
                             1'b0, '0, '0, '0, 1'b0, '0);
                state_d = S_OUT;
              end else if (cnt_q == '0) begin
                out_d = pack(ST_RELEASED, 1'b0, '0, '0, cnt_q,
                             1'b1, holder_q, hbuck_q, bucket_of(hbase_q), 1'b0, '0);
                held_d = 1'b0; holder_d = '0; hprio_d = '0; hbase_d = '0; hbuck_d = '0;
                state_d = S_OUT;
              end else begin
                state_d = S_SCANW;
              end
            end
            K_TIMEOUT: begin
              if (cnt_q == '0) begin
                out_d = pack(ST_TO_ABSENT, held_q, holder_q, hprio_q, cnt_q,
                             1'b0, '0, '0, '0, 1'b0, '0);
                state_d = S_OUT;
              end else begin
                state_d = S_SCANW;
              end
            end
            default: begin
              out_d = pack(ST_TO_ABSENT, held_q, holder_q, hprio_q, cnt_q,
                           1'b0, '0, '0, '0, 1'b0, '0);
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_SCANW: begin
        // Read of entry ptr was issued; its data arrives next cycle.
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // ram_rd holds entry ptr_q.
        if (kind_q == K_TIMEOUT) begin
          if (rd_task == tid_q) begin
            found_d = 1'b1; best_d = ptr_q;
            state_d = S_DEC;
          end else if (ptr_q + 1'b1 >= cnt_q) begin
            state_d = S_DEC;
          end else begin
            ptr_d = ptr_q + 1'b1; ram_ra = ptr_d[IdxW-1:0]; state_d = S_SCANW;
          end
        end else begin
          if (ptr_q == '0 || rd_prio < bent_q[TaskW+PrioW-1:TaskW]) begin
            bent_d = ram_rd; best_d = ptr_q;
          end
          if (ptr_q + 1'b1 >= cnt_q) begin
            state_d = S_DEC;
          end else begin
            ptr_d = ptr_q + 1'b1; ram_ra = ptr_d[IdxW-1:0]; state_d = S_SCANW;
          end
        end
      end
      S_DEC: begin
        unique case (kind_q)
          K_LOCK: begin
            if (bent_q[TaskW+PrioW-1:TaskW] < hprio_q) begin
              hprio_d = bent_q[TaskW+PrioW-1:TaskW];
              hbuck_d = bucket_of(hprio_d);
              out_d = pack(ST_QUEUED, held_q, holder_q, hprio_d, cnt_q,
                           1'b1, holder_q, hbuck_q, hbuck_d, 1'b0, '0);
            end else begin
              out_d = pack(ST_QUEUED, held_q, holder_q, hprio_q, cnt_q,
                           1'b0, '0, '0, '0, 1'b0, '0);
            end
            state_d = S_OUT;
          end
          K_UNLOCK: begin
            holder_d = bent_q[TaskW-1:0];
            hprio_d = bent_q[TaskW+PrioW-1:TaskW];
            hbase_d = bent_q[EntryW-1:TaskW+PrioW];
            hbuck_d = bucket_of(hprio_d);
            cnt_d = cnt_q - 1'b1;
            out_d = pack(ST_RELEASED, 1'b1, holder_d, hprio_d, cnt_d,
                         1'b1, holder_q, hbuck_q, bucket_of(hbase_q), 1'b1, holder_d);
            ptr_d = best_q; ram_ra = IdxW'(best_q + 1'b1);
            state_d = (best_q + 1'b1 < cnt_q) ? S_SHW : S_OUT;
          end
          default: begin
            if (found_q) begin
              cnt_d = cnt_q - 1'b1;
              out_d = pack(ST_TO_REMOVED, held_q, holder_q, hprio_q, cnt_d,
                           1'b0, '0, '0, '0, 1'b1, tid_q);
              ptr_d = best_q; ram_ra = IdxW'(best_q + 1'b1);
              state_d = (best_q + 1'b1 < cnt_q) ? S_SHW : S_OUT;
            end else begin
              out_d = pack(ST_TO_ABSENT, held_q, holder_q, hprio_q, cnt_q,
                           1'b0, '0, '0, '0, 1'b0, '0);
              state_d = S_OUT;
            end
          end
        endcase
      end
      S_SHW: begin
        // Read of entry ptr+1 was issued; keep it on the port for the next cycle.
        ram_ra = IdxW'(ptr_q + 1'b1);
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        // ram_rd holds entry ptr+1; move it down. cnt_q is already decremented.
        ram_we = 1'b1; ram_wa = ptr_q[IdxW-1:0]; ram_wd = ram_rd;
        ptr_d = ptr_q + 1'b1;
        ram_ra = IdxW'(ptr_q + 2'd2);
        state_d = (ptr_q + 2'd2 <= cnt_q) ? S_SHW : S_OUT;
      end
      S_OUT: begin
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; inh_q <= 1'b1; held_q <= 1'b0; holder_q <= '0;
      hprio_q <= '0; hbase_q <= '0; hbuck_q <= '0; cnt_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        inh_q <= cfg_wdata_i;
      end
      held_q <= held_d; holder_q <= holder_d; hprio_q <= hprio_d; hbase_q <= hbase_d;
      hbuck_q <= hbuck_d; cnt_q <= cnt_d; ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d; tid_q <= tid_d; ptr_q <= ptr_d; best_q <= best_d;
    found_q <= found_d; bent_q <= bent_d; out_q <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxWaiters)) else $error("waiter count out of range");
  a_free_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> holder_q == '0 && hprio_q == '0) else $error("free lock has owner");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !ovalid_q) else $error("stale result");
  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == S_OUT) else $error("result outside S_OUT");
`endif
endmodule
